>>> design/att_pkg.sv
package att_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;

  // Request codes.
  localparam logic [1:0] REQ_TRACK   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] pointer;
    logic [DATA_W-1:0] alloc_size;
  } att_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] released_pointer;
    logic [CNT_W-1:0]  entry_count;
    logic [DATA_W-1:0] outstanding_bytes;
    logic [DATA_W-1:0] lifetime_bytes;
    logic              last;
  } att_out_t;

  typedef struct packed {
    logic [DATA_W-1:0] pointer;
    logic [DATA_W-1:0] size;
  } att_entry_t;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } att_alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRK_OUT,
    ST_TRK_LIFE,
    ST_REL_RD,
    ST_REL_CMP,
    ST_REL_SUB,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_FL_RD,
    ST_FL_EMIT
  } att_state_t;

endpackage

>>> design/att_ram.sv
module att_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/att_alu.sv
module att_alu (
  input  att_pkg::att_alu_op_t         op,
  input  logic [att_pkg::DATA_W-1:0]   a,
  input  logic [att_pkg::DATA_W-1:0]   b,
  output logic [att_pkg::DATA_W-1:0]   res,
  output logic                         eq
);
  import att_pkg::*;

  // One adder serves both directions; the sum wraps modulo 2^32.
  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
  end

  assign eq = (a == b);

endmodule

>>> design/allocation_tracking_table.sv
// Requests answered without a table walk give their one result word in the cycle after acceptance;
// a track makes two passes through the shared adder, then gives the result. A release reads and
// compares each entry scanned, then reads and rewrites each entry shifted down; a flush reads and
// emits one result word per held entry, oldest first. A new word is taken only when busy is low,
// and the receiver cannot stall results. Synchronous active-low reset empties the table and clears
// both totals; entry storage is not cleared, as only held entries are read.
module allocation_tracking_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  att_pkg::att_in_t in_word,
  output logic             out_valid,
  output att_pkg::att_out_t out_word
);
  import att_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  // Sequencer state and the architectural registers.
  att_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] outst_r, outst_nxt;
  logic [DATA_W-1:0] life_r, life_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  att_in_t           req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  att_out_t          out_word_r, out_word_nxt;

  // Table memory port signals.
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  att_entry_t        wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  att_entry_t        rd_data;

  // Shared adder and comparator.
  att_alu_op_t       alu_op;
  logic [DATA_W-1:0] alu_a, alu_b, alu_res;
  logic              alu_eq;

  att_ram #(
    .WIDTH ($bits(att_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  att_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .eq  (alu_eq)
  );

  // Address of the entry just above the given index.
  function automatic logic [IDX_W-1:0] idx_nxt_addr(input logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] above;
    above = idx + ONE_CNT;
    return above[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      outst_r     <= '0;
      life_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      outst_r     <= outst_nxt;
      life_r      <= life_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    outst_nxt     = outst_r;
    life_nxt      = life_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    wr_en   = 1'b0;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx_r[IDX_W-1:0];

    alu_op = ALU_ADD;
    alu_a  = outst_r;
    alu_b  = req_r.alloc_size;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_word;
          idx_nxt = '0;
          // Words that need no table walk are answered straight away.
          out_word_nxt.status            = STAT_OK;
          out_word_nxt.released_pointer  = '0;
          out_word_nxt.entry_count       = count_r;
          out_word_nxt.outstanding_bytes = outst_r;
          out_word_nxt.lifetime_bytes    = life_r;
          out_word_nxt.last              = 1'b1;
          case (in_word.req_type)
            REQ_TRACK: begin
              if (count_r < DEPTH_CNT) begin
                state_nxt = ST_TRK_OUT;
              end else begin
                out_word_nxt.status = STAT_FULL;
                out_valid_nxt       = 1'b1;
              end
            end
            REQ_RELEASE: begin
              state_nxt = ST_REL_RD;
            end
            REQ_FLUSH: begin
              if (count_r == '0) begin
                out_word_nxt.status = STAT_EMPTY;
                out_valid_nxt       = 1'b1;
              end else begin
                state_nxt = ST_FL_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Append the entry and add its size to the outstanding total.
      ST_TRK_OUT: begin
        wr_en     = 1'b1;
        wr_addr   = count_r[IDX_W-1:0];
        wr_data.pointer = req_r.pointer;
        wr_data.size    = req_r.alloc_size;
        outst_nxt = alu_res;
        state_nxt = ST_TRK_LIFE;
      end

      // Second pass through the adder for the lifetime total.
      ST_TRK_LIFE: begin
        alu_a     = life_r;
        life_nxt  = alu_res;
        count_nxt = count_r + ONE_CNT;
        out_word_nxt.status            = STAT_OK;
        out_word_nxt.released_pointer  = '0;
        out_word_nxt.entry_count       = count_r + ONE_CNT;
        out_word_nxt.outstanding_bytes = outst_r;
        out_word_nxt.lifetime_bytes    = alu_res;
        out_word_nxt.last              = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      // Scan from the oldest entry; reaching the held count means no match.
      ST_REL_RD: begin
        if (idx_r == count_r) begin
          out_word_nxt.status            = STAT_NOT_FOUND;
          out_word_nxt.released_pointer  = '0;
          out_word_nxt.entry_count       = count_r;
          out_word_nxt.outstanding_bytes = outst_r;
          out_word_nxt.lifetime_bytes    = life_r;
          out_word_nxt.last              = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_REL_CMP;
        end
      end

      ST_REL_CMP: begin
        alu_a = rd_data.pointer;
        alu_b = req_r.pointer;
        if (alu_eq) begin
          state_nxt = ST_REL_SUB;
        end else begin
          idx_nxt   = idx_r + ONE_CNT;
          state_nxt = ST_REL_RD;
        end
      end

      // The matched entry's data is still held at the memory output.
      ST_REL_SUB: begin
        alu_op    = ALU_SUB;
        alu_b     = rd_data.size;
        outst_nxt = alu_res;
        state_nxt = ST_SHF_RD;
      end

      // Close the gap: fetch the next entry, then write it one place down.
      ST_SHF_RD: begin
        if ((idx_r + ONE_CNT) >= count_r) begin
          count_nxt = count_r - ONE_CNT;
          out_word_nxt.status            = STAT_OK;
          out_word_nxt.released_pointer  = '0;
          out_word_nxt.entry_count       = count_r - ONE_CNT;
          out_word_nxt.outstanding_bytes = outst_r;
          out_word_nxt.lifetime_bytes    = life_r;
          out_word_nxt.last              = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_nxt_addr(idx_r);
          state_nxt = ST_SHF_WR;
        end
      end

      ST_SHF_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        idx_nxt   = idx_r + ONE_CNT;
        state_nxt = ST_SHF_RD;
      end

      ST_FL_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_FL_EMIT;
      end

      // One result per entry, with that entry's size already taken off.
      ST_FL_EMIT: begin
        alu_op    = ALU_SUB;
        alu_b     = rd_data.size;
        outst_nxt = alu_res;
        out_word_nxt.status            = STAT_OK;
        out_word_nxt.released_pointer  = rd_data.pointer;
        out_word_nxt.entry_count       = count_r - ONE_CNT - idx_r;
        out_word_nxt.outstanding_bytes = alu_res;
        out_word_nxt.lifetime_bytes    = life_r;
        out_word_nxt.last              = ((idx_r + ONE_CNT) == count_r);
        out_valid_nxt = 1'b1;
        if ((idx_r + ONE_CNT) == count_r) begin
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + ONE_CNT;
          state_nxt = ST_FL_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A flush word that is not the final one is always followed by more work.
  a_flush_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |=> busy)
    else $error("flush stopped before its final word");

  // Every accepted word either starts a walk or is answered on the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted word produced neither work nor a result");

  // A full report only comes from a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STAT_FULL |-> out_word.entry_count == DEPTH_CNT)
    else $error("table full reported with room left");

  // The reported count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.entry_count <= DEPTH_CNT)
    else $error("entry count beyond table depth");

endmodule

>>> test/allocation_tracking_table_tb.sv
module allocation_tracking_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import att_pkg::*;

  localparam int DEPTH = 64;

  // Longest gap between the last result word and a quiet block: a release
  // on a full table stays busy while it scans or shifts every held entry,
  // and this setting leaves ample margin beyond that.
  localparam int SETTLE_CYCLES = 4 * DEPTH + 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  att_in_t  in_word = '0;
  logic     busy;
  logic     out_valid;
  att_out_t out_word;

  allocation_tracking_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Request words waiting to be driven, and the result words the predictor
  // says must come out, oldest first.
  att_in_t  pending_requests[$];
  att_out_t due_results[$];

  int   fail_count = 0;
  int   idle_pct = 0;
  logic word_taken = 1'b0;

  // The predictor's own copy of the table and both running totals.
  logic [31:0] held_ptr[DEPTH];
  logic [31:0] held_size[DEPTH];
  int unsigned held_entries = 0;
  logic [31:0] outstanding_sum = '0;
  logic [31:0] lifetime_sum = '0;

  // Pointers the stimulus generator believes are in the table when its
  // requests get applied in order. Release targets are drawn from here so
  // that most releases actually hit an entry.
  logic [31:0] planned_ptrs[$];
  logic [31:0] ptr_pool[8];

  // Applies one accepted request word to the table copy and queues the
  // result words it must produce.
  task automatic apply_request(input att_in_t w);
    att_out_t r;
    int       hit;
    r = '0;
    r.last = 1'b1;
    case (w.req_type)
      REQ_TRACK: begin
        if (held_entries < DEPTH) begin
          held_ptr[held_entries] = w.pointer;
          held_size[held_entries] = w.alloc_size;
          held_entries++;
          outstanding_sum += w.alloc_size;
          lifetime_sum += w.alloc_size;
          r.status = STAT_OK;
        end else begin
          // A full table leaves every total untouched.
          r.status = STAT_FULL;
        end
      end
      REQ_RELEASE: begin
        hit = -1;
        for (int i = 0; i < held_entries; i++) begin
          if (hit < 0 && held_ptr[i] == w.pointer) hit = i;
        end
        if (hit >= 0) begin
          // Only the oldest duplicate goes; later entries slide down one slot.
          outstanding_sum -= held_size[hit];
          for (int j = hit; j + 1 < held_entries; j++) begin
            held_ptr[j] = held_ptr[j + 1];
            held_size[j] = held_size[j + 1];
          end
          held_entries--;
          r.status = STAT_OK;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      REQ_FLUSH: begin
        if (held_entries == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // One word per held entry, oldest first, each showing the count and
          // the outstanding total with that entry already gone.
          for (int i = 0; i < held_entries; i++) begin
            outstanding_sum -= held_size[i];
            r.status = STAT_OK;
            r.released_pointer = held_ptr[i];
            r.entry_count = 7'(held_entries - 1 - i);
            r.outstanding_bytes = outstanding_sum;
            r.lifetime_bytes = lifetime_sum;
            r.last = (i + 1 == held_entries);
            due_results.push_back(r);
          end
          held_entries = 0;
          return;
        end
      end
      default: begin
        // The unused request code changes nothing and reports the state.
        r.status = STAT_OK;
      end
    endcase
    r.entry_count = 7'(held_entries);
    r.outstanding_bytes = outstanding_sum;
    r.lifetime_bytes = lifetime_sum;
    due_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endtask

  // Driver. Inputs move on the falling edge. A word stays on the port until
  // the monitor has seen it taken; then the next one follows at once unless
  // the sender chooses to idle this cycle.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // Still waiting for the block to take the current word.
    end else if (pending_requests.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
      start <= 1'b1;
      in_word <= pending_requests.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor. Everything is sampled on the rising edge. A result word that
  // leaves at the same edge as a new request is taken belongs to an older
  // request, so results are checked before the new request is predicted.
  always @(posedge clk) begin
    att_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: 0x%0h", out_word);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_word.status));
          check_field("released_pointer", want.released_pointer,
                      out_word.released_pointer);
          check_field("entry_count", 32'(want.entry_count), 32'(out_word.entry_count));
          check_field("outstanding_bytes", want.outstanding_bytes,
                      out_word.outstanding_bytes);
          check_field("lifetime_bytes", want.lifetime_bytes, out_word.lifetime_bytes);
          check_field("last", 32'(want.last), 32'(out_word.last));
        end
      end
      if (start && !busy) apply_request(in_word);
    end
    word_taken <= rst_n && start && !busy;
  end

  // Queues one request word and keeps the generator's view of the table in
  // step with it.
  task automatic send_request(input logic [1:0] req, input logic [31:0] ptr,
                              input logic [31:0] size);
    att_in_t w;
    w.req_type = req;
    w.pointer = ptr;
    w.alloc_size = size;
    pending_requests.push_back(w);
    case (req)
      REQ_TRACK: if (planned_ptrs.size() < DEPTH) planned_ptrs.push_back(ptr);
      REQ_RELEASE: begin
        for (int i = 0; i < planned_ptrs.size(); i++) begin
          if (planned_ptrs[i] == ptr) begin
            planned_ptrs.delete(i);
            break;
          end
        end
      end
      REQ_FLUSH: planned_ptrs.delete();
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom;
    if (r < 85) return $urandom_range(4096, 1);
    return (r < 92) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_pointer();
    if ($urandom_range(1, 0) != 0) return ptr_pool[$urandom_range(7, 0)];
    return $urandom;
  endfunction

  // Blocks the stimulus until every queued word has gone in and every
  // expected result word has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || due_results.size() != 0);
  endtask

  // A burst of mixed requests, biased toward releases of pointers that are
  // actually held.
  task automatic mixed_burst(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        send_request(REQ_TRACK, pick_pointer(), pick_size());
      end else if (r < 75 && planned_ptrs.size() != 0) begin
        send_request(REQ_RELEASE, planned_ptrs[$urandom_range(planned_ptrs.size() - 1, 0)],
                     $urandom);
      end else if (r < 83) begin
        send_request(REQ_RELEASE, $urandom, $urandom);
      end else if (r < 90) begin
        send_request(REQ_UNUSED, $urandom, $urandom);
      end else begin
        send_request(REQ_FLUSH, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int phase_pct[4];
    int target;

    // Sender idle share per phase. The result side cannot hold words off, so
    // the phases meant to stall it run the sender flat out instead.
    phase_pct = '{0, 78, 0, 7};
    foreach (ptr_pool[i]) ptr_pool[i] = $urandom;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-table corners, field extremes, duplicates,
    // total wraparound and the unused request code.
    send_request(REQ_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'h0, 32'h0);
    send_request(REQ_UNUSED, 32'h0, 32'h0);
    send_request(REQ_TRACK, 32'h0, 32'h0);
    send_request(REQ_TRACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_TRACK, 32'h0000_1234, 32'd5);
    send_request(REQ_TRACK, 32'h0000_1234, 32'd7);
    send_request(REQ_TRACK, 32'hA5A5_A5A5, 32'd1);
    send_request(REQ_RELEASE, 32'h0000_1234, 32'h0);
    send_request(REQ_RELEASE, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_FLUSH, 32'h0, 32'h0);
    send_request(REQ_FLUSH, 32'h0, 32'h0);
    send_request(REQ_TRACK, 32'h5A5A_5A5A, 32'h8000_0000);
    send_request(REQ_TRACK, 32'h5A5A_5A5A, 32'h8000_0001);
    send_request(REQ_TRACK, 32'h0000_0001, 32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'h0, 32'h0);
    send_request(REQ_RELEASE, 32'h5A5A_5A5A, 32'h0);
    send_request(REQ_FLUSH, 32'h0, 32'h0);
    wait_drained();

    // Random part. Each phase first fills the table past full, so that full
    // rejections and long scans and shifts occur, then runs mixed bursts. The
    // wait at the end of each phase also pauses the sender until every
    // expected word is back.
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      target = pending_requests.size() + 125;
      while (planned_ptrs.size() < DEPTH) send_request(REQ_TRACK, pick_pointer(), pick_size());
      repeat ($urandom_range(3, 1)) send_request(REQ_TRACK, $urandom, pick_size());
      while (pending_requests.size() < target) mixed_burst($urandom_range(12, 1));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d result words never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
